@@ rtl/spt_pkg.sv @@
// Shared types and codes for the sorted point table.
`default_nettype none

package spt_pkg;

  typedef enum logic [1:0] {
    REQ_FIND   = 2'd0,
    REQ_SET    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_CLEAN  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DECIDE,
    ST_SHIFT_UP,
    ST_PLACE,
    ST_SHIFT_DN,
    ST_RESULT
  } state_t;

  localparam int FIELD_W = 32;
  localparam int COUNT_W = 9;

  typedef struct packed {
    req_t                      req_type;
    logic signed [FIELD_W-1:0] key_z;
    logic signed [FIELD_W-1:0] coord_x;
    logic signed [FIELD_W-1:0] coord_y;
  } spt_req_t;

  typedef struct packed {
    status_t                   status;
    logic signed [FIELD_W-1:0] found_x;
    logic signed [FIELD_W-1:0] found_y;
    logic [COUNT_W-1:0]        entry_count;
    logic                      dirty_flag;
  } spt_result_t;

endpackage

`default_nettype wire

@@ rtl/spt_core.sv @@
// Table sequencer: binary search, update and shift over one entry memory.
`default_nettype none

module spt_core #(
  parameter int TABLE_DEPTH = 256,
  parameter int COORD_BITS  = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire spt_pkg::spt_req_t   req,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output spt_pkg::spt_result_t     res
);

  import spt_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = 3 * COORD_BITS;

  // Entry memory, packed {y, x, key}
  logic [EW-1:0] mem [TABLE_DEPTH];
  logic [EW-1:0] rd_data_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  state_t state_r, state_nxt;
  req_t   req_r, req_nxt;
  logic signed [COORD_BITS-1:0] key_r, key_nxt;
  logic signed [COORD_BITS-1:0] x_r, x_nxt;
  logic signed [COORD_BITS-1:0] y_r, y_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [AW-1:0] mid_r, mid_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          dirty_r, dirty_nxt;
  status_t       status_r, status_nxt;
  logic signed [FIELD_W-1:0] fx_r, fx_nxt;
  logic signed [FIELD_W-1:0] fy_r, fy_nxt;

  logic signed [COORD_BITS-1:0] rd_key, rd_x, rd_y;
  logic signed [COORD_BITS-1:0] in_key, in_x, in_y;
  logic          accept;
  logic          key_lt;
  logic [CW-1:0] lo_n, hi_n;
  logic [CW:0]   mid_sum;
  logic [AW-1:0] mid_n;
  logic          go_on;
  logic          hit;
  logic          full;
  logic          rm_shift;
  logic          up_last;
  logic          dn_last;
  logic [EW-1:0] new_entry;

  assign rd_key = rd_data_r[COORD_BITS-1:0];
  assign rd_x   = rd_data_r[2*COORD_BITS-1:COORD_BITS];
  assign rd_y   = rd_data_r[3*COORD_BITS-1:2*COORD_BITS];

  // Narrow or sign-extend the 32-bit fields to the stored width
  assign in_key = COORD_BITS'(req.key_z);
  assign in_x   = COORD_BITS'(req.coord_x);
  assign in_y   = COORD_BITS'(req.coord_y);

  assign req_ready = (state_r == ST_IDLE);
  assign accept    = req_valid && req_ready;

  // One probe per cycle: compare the word read last cycle, narrow the range,
  // issue the next probe
  assign key_lt  = rd_key < key_r;
  assign lo_n    = key_lt ? (CW'(mid_r) + CW'(1)) : lo_r;
  assign hi_n    = key_lt ? hi_r : CW'(mid_r);
  assign mid_sum = (CW + 1)'(lo_n) + (CW + 1)'(hi_n);
  assign mid_n   = AW'(mid_sum >> 1);
  assign go_on   = lo_n < hi_n;

  assign hit       = (pos_r < fill_r) && (rd_key == key_r);
  assign full      = (fill_r == CW'(TABLE_DEPTH));
  assign rm_shift  = ((CW + 1)'(pos_r) + (CW + 1)'(1)) < (CW + 1)'(fill_r);
  assign up_last   = (CW'(idx_r) == pos_r);
  assign dn_last   = ((CW + 1)'(idx_r) + (CW + 1)'(1)) == (CW + 1)'(fill_r);
  assign new_entry = {y_r, x_r, key_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (fill_r == '0) ? ST_DECIDE : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (!go_on) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        unique case (req_r)
          REQ_SET: begin
            if (hit || full || pos_r == fill_r) begin
              state_nxt = ST_RESULT;
            end else begin
              state_nxt = ST_SHIFT_UP;
            end
          end
          REQ_REMOVE: begin
            state_nxt = (hit && rm_shift) ? ST_SHIFT_DN : ST_RESULT;
          end
          default: state_nxt = ST_RESULT;
        endcase
      end
      ST_SHIFT_UP: begin
        if (up_last) begin
          state_nxt = ST_PLACE;
        end
      end
      ST_PLACE:    state_nxt = ST_RESULT;
      ST_SHIFT_DN: begin
        if (dn_last) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    req_nxt    = req_r;
    key_nxt    = key_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    mid_nxt    = mid_r;
    pos_nxt    = pos_r;
    idx_nxt    = idx_r;
    fill_nxt   = fill_r;
    dirty_nxt  = dirty_r;
    status_nxt = status_r;
    fx_nxt     = fx_r;
    fy_nxt     = fy_r;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = '0;
    res_valid  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_nxt    = req.req_type;
          key_nxt    = in_key;
          x_nxt      = in_x;
          y_nxt      = in_y;
          lo_nxt     = '0;
          hi_nxt     = fill_r;
          mid_nxt    = AW'(fill_r >> 1);
          pos_nxt    = '0;
          status_nxt = STAT_OK;
          fx_nxt     = '0;
          fy_nxt     = '0;
          rd_en      = 1'b1;
          rd_addr    = (fill_r == '0) ? '0 : AW'(fill_r >> 1);
        end
      end
      ST_SEARCH: begin
        rd_en = 1'b1;
        if (go_on) begin
          lo_nxt  = lo_n;
          hi_nxt  = hi_n;
          mid_nxt = mid_n;
          rd_addr = mid_n;
        end else begin
          pos_nxt = lo_n;
          rd_addr = AW'(lo_n);
        end
      end
      ST_DECIDE: begin
        unique case (req_r)
          REQ_FIND: begin
            if (hit) begin
              fx_nxt = FIELD_W'(rd_x);
              fy_nxt = FIELD_W'(rd_y);
            end else begin
              status_nxt = STAT_NOT_FOUND;
            end
          end
          REQ_SET: begin
            if (hit) begin
              wr_en     = 1'b1;
              wr_addr   = AW'(pos_r);
              wr_data   = new_entry;
              dirty_nxt = 1'b1;
            end else if (full) begin
              status_nxt = STAT_FULL;
            end else if (pos_r == fill_r) begin
              wr_en     = 1'b1;
              wr_addr   = AW'(pos_r);
              wr_data   = new_entry;
              fill_nxt  = fill_r + CW'(1);
              dirty_nxt = 1'b1;
            end else begin
              // Open a gap: move the top entry first
              idx_nxt = AW'(fill_r - CW'(1));
              rd_en   = 1'b1;
              rd_addr = AW'(fill_r - CW'(1));
            end
          end
          REQ_REMOVE: begin
            if (hit) begin
              if (rm_shift) begin
                idx_nxt = AW'(pos_r + CW'(1));
                rd_en   = 1'b1;
                rd_addr = AW'(pos_r + CW'(1));
              end else begin
                fill_nxt  = fill_r - CW'(1);
                dirty_nxt = 1'b1;
              end
            end else begin
              status_nxt = STAT_NOT_FOUND;
            end
          end
          REQ_CLEAN: dirty_nxt = 1'b0;
          default: ;
        endcase
      end
      ST_SHIFT_UP: begin
        wr_en   = 1'b1;
        wr_addr = idx_r + AW'(1);
        wr_data = rd_data_r;
        if (!up_last) begin
          idx_nxt = idx_r - AW'(1);
          rd_en   = 1'b1;
          rd_addr = idx_r - AW'(1);
        end
      end
      ST_PLACE: begin
        wr_en     = 1'b1;
        wr_addr   = AW'(pos_r);
        wr_data   = new_entry;
        fill_nxt  = fill_r + CW'(1);
        dirty_nxt = 1'b1;
      end
      ST_SHIFT_DN: begin
        wr_en   = 1'b1;
        wr_addr = idx_r - AW'(1);
        wr_data = rd_data_r;
        if (dn_last) begin
          fill_nxt  = fill_r - CW'(1);
          dirty_nxt = 1'b1;
        end else begin
          idx_nxt = idx_r + AW'(1);
          rd_en   = 1'b1;
          rd_addr = idx_r + AW'(1);
        end
      end
      ST_RESULT: res_valid = 1'b1;
      default: ;
    endcase
  end

  assign res.status      = status_r;
  assign res.found_x     = fx_r;
  assign res.found_y     = fy_r;
  assign res.entry_count = COUNT_W'(fill_r);
  assign res.dirty_flag  = dirty_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      dirty_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      dirty_r <= dirty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    key_r    <= key_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    pos_r    <= pos_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    fx_r     <= fx_nxt;
    fy_r     <= fy_nxt;
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && fill_r != $past(fill_r)) |->
      (fill_r == $past(fill_r) + CW'(1) || fill_r == $past(fill_r) - CW'(1)))
    else $error("entry count moved by more than one");

  a_no_stray_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_SEARCH || state_r == ST_RESULT) |-> !wr_en)
    else $error("memory write outside an update");

  a_up_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT_UP) |-> (CW'(idx_r) >= pos_r && CW'(idx_r) < fill_r))
    else $error("insert shift index out of range");

  a_dn_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT_DN) |-> (CW'(idx_r) > pos_r && CW'(idx_r) < fill_r))
    else $error("remove shift index out of range");
`endif

endmodule

`default_nettype wire

@@ rtl/sorted_point_table.sv @@
// Sorted point table: lookup, upsert, removal and dirty-flag clean on a key-ordered entry memory.
// Each request first binary-searches the n entries held, one probe a cycle; find, mark clean,
//   overwrite and refused insert then finish without moving any entry.
// Insert before the end moves (n - p) entries up, an append moves none, and remove moves
//   (n - p - 1) entries down, one memory read and one write per moved entry (p = sorted position).
// One request at a time; the next word is taken once the result sits in the output register.
// Reset (rst_n low, synchronous) empties the table and clears the dirty flag; no memory sweep.
`default_nettype none

module sorted_point_table #(
  parameter int TABLE_DEPTH = 256,
  parameter int COORD_BITS  = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [95:0] in_tdata,  // key_z[31:0], coord_x[63:32], coord_y[95:64]
  input  wire logic [1:0]  in_tuser,  // req_type[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata, // found_x[31:0], found_y[63:32], entry_count[72:64],
                                      // dirty_flag[73], zero[79:74]
  output logic [1:0]       out_tuser  // status[1:0]
);

  import spt_pkg::*;

  spt_req_t    req;
  spt_result_t res;
  spt_result_t out_res_r, out_res_nxt;
  logic        res_valid;
  logic        res_ready;
  logic        out_valid_r, out_valid_nxt;

  assign req.req_type = req_t'(in_tuser);
  assign req.key_z    = in_tdata[31:0];
  assign req.coord_x  = in_tdata[63:32];
  assign req.coord_y  = in_tdata[95:64];

  spt_core #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COORD_BITS  (COORD_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Load the output register when it is empty or being drained
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {6'd0, out_res_r.dirty_flag, out_res_r.entry_count,
                       out_res_r.found_y, out_res_r.found_x};

endmodule

`default_nettype wire
